/* sv/fpsl_pkg.sv */
// ----------------------------------------------------------------------------
// fpsl_pkg: shared types and constants of the passive serial loader
// Command, phase and status codes, register indexes and the item structs.
// ----------------------------------------------------------------------------
package fpsl_pkg;

    // width of the image byte counter
    parameter int COUNT_BITS = 24;

    parameter int CFG_IDX_W  = 3;
    parameter int CFG_DATA_W = 24;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [23:0]           t_bytes;

    parameter logic [9:0]  WAIT_MAX = 10'd1023;
    parameter logic [9:0]  POLL_MAX = 10'd1023;
    parameter logic [22:0] PAD_MAX  = 23'h7FFFFF;
    parameter logic [7:0]  PAD_BYTE = 8'hFF;

    parameter logic [23:0] RST_IMAGE_BYTES   = 24'd0;
    parameter logic [7:0]  RST_SETTLE_US     = 8'd40;
    parameter logic [9:0]  RST_POLL_INTERVAL = 10'd100;
    parameter logic [9:0]  RST_POLL_LIMIT    = 10'd500;
    parameter logic [22:0] RST_PAD_LIMIT     = 23'd5000000;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_BYTE  = 2'd2,
        CMD_PAD   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SETTLE  = 4'd1,
        PH_PULSE   = 4'd2,
        PH_HOLD    = 4'd3,
        PH_RELEASE = 4'd4,
        PH_POLL    = 4'd5,
        PH_IMAGE   = 4'd6,
        PH_PAD     = 4'd7,
        PH_END     = 4'd8
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE               = 4'd0,
        ST_BUSY               = 4'd1,
        ST_DONE               = 4'd2,
        ST_STATUS_AT_PULSE    = 4'd3,
        ST_DONE_AT_PULSE      = 4'd4,
        ST_DONE_AFTER_RELEASE = 4'd5,
        ST_TIMEOUT            = 4'd6,
        ST_LOST               = 4'd7,
        ST_PAD_OUT            = 4'd8
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_BYTES   = 3'd0,
        CFG_SETTLE_US     = 3'd1,
        CFG_POLL_INTERVAL = 3'd2,
        CFG_POLL_LIMIT    = 3'd3,
        CFG_PAD_LIMIT     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [23:0] image_bytes;
        logic [7:0]  settle_us;
        logic [9:0]  poll_interval_us;
        logic [9:0]  poll_limit;
        logic [22:0] pad_limit;
    } t_cfg;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
        logic       status_pin;
        logic       done_pin;
    } t_in_item;

    typedef struct packed {
        logic        config_request;
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        want_data;
        logic [3:0]  status;
        logic [23:0] bytes_sent;
    } t_result;

endpackage

/* sv/fpsl_in_if.sv */
// ----------------------------------------------------------------------------
// fpsl_in_if: input channel of the passive serial loader
// Valid/ready channel carrying command, image byte and pin samples.
// ----------------------------------------------------------------------------
interface fpsl_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic       status_pin;
    logic       done_pin;

    modport source (output valid, cmd, data_byte, status_pin, done_pin, input ready);
    modport sink   (input valid, cmd, data_byte, status_pin, done_pin, output ready);
endinterface

/* sv/fpsl_out_if.sv */
// ----------------------------------------------------------------------------
// fpsl_out_if: result channel of the passive serial loader
// Valid/ready channel carrying pin level, send byte and progress status.
// ----------------------------------------------------------------------------
interface fpsl_out_if;
    logic        valid;
    logic        ready;
    logic        config_request;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        want_data;
    logic [3:0]  status;
    logic [23:0] bytes_sent;

    modport source (output valid, config_request, send_valid, send_byte, want_data,
                    status, bytes_sent, input ready);
    modport sink   (input valid, config_request, send_valid, send_byte, want_data,
                    status, bytes_sent, output ready);
endinterface

/* sv/fpsl_cfg_regs.sv */
// ----------------------------------------------------------------------------
// fpsl_cfg_regs: configuration registers
// Write-only register file; each write lands at the next clock edge.
// ----------------------------------------------------------------------------
module fpsl_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fpsl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fpsl_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output fpsl_pkg::t_cfg                   o_cfg
);

    fpsl_pkg::t_cfg r_cfg;
    fpsl_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (fpsl_pkg::t_cfg_idx'(i_cfg_idx))
                fpsl_pkg::CFG_IMAGE_BYTES:   n_cfg.image_bytes      = i_cfg_wdata[23:0];
                fpsl_pkg::CFG_SETTLE_US:     n_cfg.settle_us        = i_cfg_wdata[7:0];
                fpsl_pkg::CFG_POLL_INTERVAL: n_cfg.poll_interval_us = i_cfg_wdata[9:0];
                fpsl_pkg::CFG_POLL_LIMIT:    n_cfg.poll_limit       = i_cfg_wdata[9:0];
                fpsl_pkg::CFG_PAD_LIMIT:     n_cfg.pad_limit        = i_cfg_wdata[22:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_bytes      <= fpsl_pkg::RST_IMAGE_BYTES;
            r_cfg.settle_us        <= fpsl_pkg::RST_SETTLE_US;
            r_cfg.poll_interval_us <= fpsl_pkg::RST_POLL_INTERVAL;
            r_cfg.poll_limit       <= fpsl_pkg::RST_POLL_LIMIT;
            r_cfg.pad_limit        <= fpsl_pkg::RST_PAD_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/fpsl_core.sv */
// ----------------------------------------------------------------------------
// fpsl_core: load sequencer
// Phase register and counters; one step per item, result formed alongside.
// ----------------------------------------------------------------------------
module fpsl_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  fpsl_pkg::t_in_item i_item,
    input  fpsl_pkg::t_cfg     i_cfg,
    output fpsl_pkg::t_result  o_result
);

    fpsl_pkg::t_phase  r_phase,       n_phase;
    logic [9:0]        r_wait_cnt,    n_wait_cnt;
    logic [9:0]        r_poll_cnt,    n_poll_cnt;
    fpsl_pkg::t_count  r_byte_cnt,    n_byte_cnt;
    logic [22:0]       r_pad_cnt,     n_pad_cnt;
    fpsl_pkg::t_status r_last_status, n_last_status;

    logic [9:0]        wait_inc;
    logic [9:0]        wait_lim;
    logic              wait_hit;
    logic [9:0]        poll_inc;
    logic [22:0]       pad_inc;
    fpsl_pkg::t_count  img_len;
    fpsl_pkg::t_count  byte_inc;
    logic              send_valid;
    logic [7:0]        send_byte;

    // shared increment/compare for all waiting phases
    assign wait_inc = (r_wait_cnt != fpsl_pkg::WAIT_MAX) ? r_wait_cnt + 10'd1 : r_wait_cnt;
    assign wait_lim = (r_phase == fpsl_pkg::PH_POLL) ? i_cfg.poll_interval_us
                                                     : {2'b00, i_cfg.settle_us};
    assign wait_hit = (wait_inc >= wait_lim);
    assign poll_inc = (r_poll_cnt != fpsl_pkg::POLL_MAX) ? r_poll_cnt + 10'd1 : r_poll_cnt;
    assign pad_inc  = (r_pad_cnt != fpsl_pkg::PAD_MAX) ? r_pad_cnt + 23'd1 : r_pad_cnt;
    assign img_len  = fpsl_pkg::t_count'(i_cfg.image_bytes);
    assign byte_inc = r_byte_cnt + fpsl_pkg::t_count'(1);

    always_comb begin
        n_phase       = r_phase;
        n_wait_cnt    = r_wait_cnt;
        n_poll_cnt    = r_poll_cnt;
        n_byte_cnt    = r_byte_cnt;
        n_pad_cnt     = r_pad_cnt;
        n_last_status = r_last_status;
        send_valid    = 1'b0;
        send_byte     = 8'h00;

        case (i_item.cmd)
            fpsl_pkg::CMD_START: begin
                n_phase       = fpsl_pkg::PH_SETTLE;
                n_wait_cnt    = '0;
                n_poll_cnt    = '0;
                n_byte_cnt    = '0;
                n_pad_cnt     = '0;
                n_last_status = fpsl_pkg::ST_BUSY;
            end
            fpsl_pkg::CMD_TICK: begin
                case (r_phase)
                    fpsl_pkg::PH_SETTLE: begin
                        n_wait_cnt = wait_hit ? 10'd0 : wait_inc;
                        if (wait_hit) n_phase = fpsl_pkg::PH_PULSE;
                    end
                    fpsl_pkg::PH_PULSE: begin
                        if (i_item.status_pin) begin
                            n_phase       = fpsl_pkg::PH_END;
                            n_last_status = fpsl_pkg::ST_STATUS_AT_PULSE;
                        end else if (i_item.done_pin) begin
                            n_phase       = fpsl_pkg::PH_END;
                            n_last_status = fpsl_pkg::ST_DONE_AT_PULSE;
                        end else begin
                            n_phase    = fpsl_pkg::PH_HOLD;
                            n_wait_cnt = '0;
                        end
                    end
                    fpsl_pkg::PH_HOLD: begin
                        n_wait_cnt = wait_hit ? 10'd0 : wait_inc;
                        if (wait_hit) n_phase = fpsl_pkg::PH_RELEASE;
                    end
                    fpsl_pkg::PH_RELEASE: begin
                        n_wait_cnt = wait_hit ? 10'd0 : wait_inc;
                        if (wait_hit) begin
                            if (i_item.done_pin) begin
                                n_phase       = fpsl_pkg::PH_END;
                                n_last_status = fpsl_pkg::ST_DONE_AFTER_RELEASE;
                            end else if (i_item.status_pin) begin
                                n_phase = (img_len == '0) ? fpsl_pkg::PH_PAD
                                                          : fpsl_pkg::PH_IMAGE;
                            end else begin
                                n_phase    = fpsl_pkg::PH_POLL;
                                n_poll_cnt = '0;
                            end
                        end
                    end
                    fpsl_pkg::PH_POLL: begin
                        n_wait_cnt = wait_hit ? 10'd0 : wait_inc;
                        if (wait_hit) begin
                            n_poll_cnt = poll_inc;
                            if (poll_inc >= i_cfg.poll_limit) begin
                                n_phase       = fpsl_pkg::PH_END;
                                n_last_status = fpsl_pkg::ST_TIMEOUT;
                            end else if (i_item.status_pin) begin
                                n_phase = (img_len == '0) ? fpsl_pkg::PH_PAD
                                                          : fpsl_pkg::PH_IMAGE;
                            end
                        end
                    end
                    default: ;  // ticks in the idle, image, pad and end phases are ignored
                endcase
            end
            fpsl_pkg::CMD_BYTE: begin
                if (r_phase == fpsl_pkg::PH_IMAGE) begin
                    if (r_byte_cnt >= img_len) begin
                        n_phase = fpsl_pkg::PH_PAD;
                    end else if (i_item.done_pin) begin
                        n_phase       = fpsl_pkg::PH_END;
                        n_last_status = fpsl_pkg::ST_DONE;
                    end else if (!i_item.status_pin) begin
                        n_phase       = fpsl_pkg::PH_END;
                        n_last_status = fpsl_pkg::ST_LOST;
                    end else begin
                        send_valid = 1'b1;
                        send_byte  = i_item.data_byte;
                        n_byte_cnt = byte_inc;
                        if (byte_inc >= img_len) n_phase = fpsl_pkg::PH_PAD;
                    end
                end
            end
            fpsl_pkg::CMD_PAD: begin
                if (r_phase == fpsl_pkg::PH_PAD) begin
                    send_valid = 1'b1;
                    send_byte  = fpsl_pkg::PAD_BYTE;
                    n_pad_cnt  = pad_inc;
                    if (i_item.done_pin) begin
                        n_phase       = fpsl_pkg::PH_END;
                        n_last_status = fpsl_pkg::ST_DONE;
                    end else if (pad_inc >= i_cfg.pad_limit) begin
                        n_phase       = fpsl_pkg::PH_END;
                        n_last_status = fpsl_pkg::ST_PAD_OUT;
                    end
                end
            end
            default: ;
        endcase

        o_result.config_request = !(n_phase == fpsl_pkg::PH_PULSE ||
                                    n_phase == fpsl_pkg::PH_HOLD);
        o_result.send_valid     = send_valid;
        o_result.send_byte      = send_byte;
        o_result.want_data      = (n_phase == fpsl_pkg::PH_IMAGE) && (n_byte_cnt < img_len);
        o_result.status         = n_last_status;
        o_result.bytes_sent     = fpsl_pkg::t_bytes'(n_byte_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= fpsl_pkg::PH_IDLE;
            r_wait_cnt    <= '0;
            r_poll_cnt    <= '0;
            r_byte_cnt    <= '0;
            r_pad_cnt     <= '0;
            r_last_status <= fpsl_pkg::ST_IDLE;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_wait_cnt    <= n_wait_cnt;
            r_poll_cnt    <= n_poll_cnt;
            r_byte_cnt    <= n_byte_cnt;
            r_pad_cnt     <= n_pad_cnt;
            r_last_status <= n_last_status;
        end
    end

    a_send_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_result.send_valid) |->
            (r_phase == fpsl_pkg::PH_IMAGE || r_phase == fpsl_pkg::PH_PAD))
        else $error("byte sent outside image or pad phase");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.cmd == fpsl_pkg::CMD_START) |=>
            (r_phase == fpsl_pkg::PH_SETTLE && r_byte_cnt == '0 &&
             r_last_status == fpsl_pkg::ST_BUSY))
        else $error("start did not restart the sequence");

    a_end_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == fpsl_pkg::PH_END) |->
            (r_last_status != fpsl_pkg::ST_IDLE && r_last_status != fpsl_pkg::ST_BUSY))
        else $error("finished without a final status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_byte_cnt) && $stable(r_pad_cnt)))
        else $error("state moved without a step");

endmodule

/* sv/fpga_passive_serial_loader.sv */
// Path: input beat to result beat through the input register, then the result register.
// Throughput: 1 item per cycle when not stalled; the phase/counter update in the core is the only loop.
// Reset: synchronous, active low; phase idle, all counts zero, status idle, registers
//   at their defaults (image 0, settle 40, poll interval 100, poll limit 500, pad 5000000).
// A stalled result beat holds; the input register still takes a beat while it is empty,
//   or while the result register is free or being drained in the same cycle.
// ----------------------------------------------------------------------------
// fpga_passive_serial_loader: passive serial configuration sequencer
// Steps through request pulse, release, status polling, image stream and padding,
// one result beat per input beat.
// ----------------------------------------------------------------------------
module fpga_passive_serial_loader (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fpsl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fpsl_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    fpsl_in_if.sink                          i_in,
    fpsl_out_if.source                       o_out
);

    // configuration registers; the user must write them only while the block is idle (not enforced here)
    fpsl_pkg::t_cfg cfg;

    fpsl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // input register stage
    logic               r_in_valid, n_in_valid;
    fpsl_pkg::t_in_item r_in;
    logic               out_free;
    logic               in_accept;
    logic               step;

    // result register stage
    logic               r_out_valid, n_out_valid;
    fpsl_pkg::t_result  r_out;
    fpsl_pkg::t_result  core_result;

    // the result register is free when empty or being drained this cycle
    assign out_free  = !r_out_valid || o_out.ready;
    // advance the held beat into the core when the result slot is free
    assign step      = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;
    assign in_accept = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (step) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers: input captures on accept, result captures on step, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.cmd        <= fpsl_pkg::t_cmd'(i_in.cmd);
            r_in.data_byte  <= i_in.data_byte;
            r_in.status_pin <= i_in.status_pin;
            r_in.done_pin   <= i_in.done_pin;
        end
        if (step) begin
            r_out <= core_result;
        end
    end

    // sequencer: state update and result formed in one pass
    fpsl_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    // drive the result channel straight from the result register
    assign o_out.valid          = r_out_valid;
    assign o_out.config_request = r_out.config_request;
    assign o_out.send_valid     = r_out.send_valid;
    assign o_out.send_byte      = r_out.send_byte;
    assign o_out.want_data      = r_out.want_data;
    assign o_out.status         = r_out.status;
    assign o_out.bytes_sent     = r_out.bytes_sent;

endmodule
